### sv/stb_pkg.sv
`timescale 1ns / 1ps

package stb_pkg;

  localparam int CHANNELS  = 64;
  localparam int LEVELS    = 3;

  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LV_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TBL_W     = 16;
  localparam int SIGMA_W   = 8;
  localparam int NUM_SIGMA = 3;
  localparam int CNT_W     = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int DIFF_W    = CNT_W + 9;
  localparam int PROD_W    = DIFF_W + TBL_W + 1;
  localparam int RND_SHIFT = 12;
  localparam int RND_HALF  = 1 << (RND_SHIFT - 1);

  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  localparam logic [SIGMA_W-1:0] SIGMA_LOW_RST  = 8'd48;
  localparam logic [SIGMA_W-1:0] SIGMA_MID_RST  = 8'd64;
  localparam logic [SIGMA_W-1:0] SIGMA_HIGH_RST = 8'd80;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_STD    = 2'd1,
    OP_MEAN   = 2'd2,
    OP_INV    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CLS_SAMPLE = 2'd0,
    CLS_MEAN   = 2'd1,
    CLS_INV    = 2'd2
  } cls_t;

  typedef enum logic [1:0] {
    CFG_SIGMA_LOW  = 2'd0,
    CFG_SIGMA_MID  = 2'd1,
    CFG_SIGMA_HIGH = 2'd2
  } cfg_idx_t;

  typedef logic [NUM_SIGMA-1:0][SIGMA_W-1:0] sigma_t;
  typedef logic [LEVELS-1:0][CNT_W-1:0] cnt_vec_t;

  // Classified work item passed from the front end to the back end.
  typedef struct packed {
    cls_t              cls;
    logic [CH_AW-1:0]  ch;
    logic [LV_W-1:0]   lv;
    logic [TBL_W-1:0]  tv;
    logic              bin_end;
    logic [LEVELS-1:0] hit;
  } stb_item_t;

endpackage

### sv/stb_in_if.sv
`timescale 1ns / 1ps

interface stb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  channel;
  logic [1:0]  level;
  logic signed [15:0] sample;
  logic        bin_end;
  logic [15:0] table_value;

  modport source (
    output valid, operation, channel, level, sample, bin_end, table_value,
    input  ready
  );
  modport sink (
    input  valid, operation, channel, level, sample, bin_end, table_value,
    output ready
  );
endinterface

### sv/stb_out_if.sv
`timescale 1ns / 1ps

interface stb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  feature_index;
  logic signed [15:0] feature_value;
  logic        last;

  modport source (
    output valid, feature_index, feature_value, last,
    input  ready
  );
  modport sink (
    input  valid, feature_index, feature_value, last,
    output ready
  );
endinterface

### sv/stb_ram.sv
`timescale 1ns / 1ps

module stb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/stb_front.sv
`timescale 1ns / 1ps

module stb_front import stb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sigma_t     sigma,
  stb_in_if.sink     in_ch,
  output logic       push_valid,
  input  logic       push_ready,
  output stb_item_t  push_item
);

  logic             f_valid_r, f_valid_nxt;
  stb_item_t        f_item_r;
  logic [15:0]      f_sample_r;
  logic [TBL_W-1:0] std_rd;

  logic             in_range, lv_ok, keep, acc;
  cls_t             cls;
  logic [CH_AW-1:0] ch;
  logic [16:0]      mag;
  logic [24:0]      mag12;
  logic [SIGMA_W+TBL_W-1:0] thr [LEVELS];
  logic [LEVELS-1:0] hit;

  assign ch       = CH_AW'(in_ch.channel);
  assign in_range = 32'(in_ch.channel) < CHANNELS;
  assign lv_ok    = 32'(in_ch.level) < LEVELS;
  assign acc      = in_ch.valid && in_ch.ready;

  // Sort the operation: std loads finish here, out-of-range items drop.
  always_comb begin
    cls  = CLS_SAMPLE;
    keep = 1'b0;
    case (op_t'(in_ch.operation))
      OP_SAMPLE: begin
        cls  = CLS_SAMPLE;
        keep = in_range;
      end
      OP_MEAN: begin
        cls  = CLS_MEAN;
        keep = in_range && lv_ok;
      end
      OP_INV: begin
        cls  = CLS_INV;
        keep = in_range && lv_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  stb_ram #(.WIDTH(TBL_W), .DEPTH(CHANNELS)) u_std (
    .clk     (clk),
    .we      (acc && in_range && (op_t'(in_ch.operation) == OP_STD)),
    .waddr   (ch),
    .wdata   (in_ch.table_value),
    .re      (acc && keep),
    .raddr   (ch),
    .rd_data (std_rd)
  );

  assign push_valid  = f_valid_r;
  assign in_ch.ready = !f_valid_r || push_ready;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (in_ch.ready) begin
      f_valid_nxt = acc && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && keep) begin
      f_item_r.cls     <= cls;
      f_item_r.ch      <= ch;
      f_item_r.lv      <= LV_W'(in_ch.level);
      f_item_r.tv      <= in_ch.table_value;
      f_item_r.bin_end <= in_ch.bin_end;
      f_item_r.hit     <= '0;
      f_sample_r       <= in_ch.sample;
    end
  end

  // Magnitude in Q17.8 against sigma times std, strictly greater.
  assign mag   = f_sample_r[15] ? (17'h10000 - {1'b0, f_sample_r}) : {1'b0, f_sample_r};
  assign mag12 = {mag, 8'b0};

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      thr[l] = sigma[l] * std_rd;
      hit[l] = mag12 > {1'b0, thr[l]};
    end
  end

  always_comb begin
    push_item     = f_item_r;
    push_item.hit = hit;
  end

endmodule

### sv/stb_queue.sv
`timescale 1ns / 1ps

module stb_queue import stb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  stb_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output stb_item_t pop_item
);

  stb_item_t      slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign push_ready = fill_r != (QAW+1)'(QDEPTH);
  assign pop_valid  = fill_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### sv/stb_back.sv
`timescale 1ns / 1ps

module stb_back import stb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  stb_item_t q_item,
  stb_out_if.source out_ch
);

  localparam logic signed [PROD_W-1:0] SAT_HI = 32767;
  localparam logic signed [PROD_W-1:0] SAT_LO = -32768;

  // Count stage
  logic            b2_valid_r, b2_valid_nxt;
  stb_item_t       b2_r;
  logic [LV_W-1:0] b2_lvl_r, b2_lvl_nxt;
  logic            fwd_hit_r;
  cnt_vec_t        fwd_cnt_r;
  logic [CHANNELS-1:0] cnt_vld_r;

  logic [CNT_W-1:0] cnt_rd  [LEVELS];
  logic [TBL_W-1:0] mean_rd [LEVELS];
  logic [TBL_W-1:0] inv_rd  [LEVELS];
  cnt_vec_t         cnt_old, cnt_new, cnt_wdata;

  logic pop, is_sample, emit, last_lvl, b2_retire, cnt_we, p1_load;

  // Feature pipeline
  logic                     p1_valid_r, p2_valid_r, out_valid_r;
  logic signed [DIFF_W-1:0] p1_diff_r;
  logic [TBL_W-1:0]         p1_inv_r;
  logic [7:0]               p1_idx_r, p2_idx_r, out_idx_r;
  logic                     p1_last_r, p2_last_r, out_last_r;
  logic signed [PROD_W-1:0] p2_prod_r;
  logic signed [15:0]       out_value_r;
  logic                     out_adv, p2_adv, p1_adv;
  logic signed [PROD_W-1:0] rnd;
  logic signed [15:0]       sat_value;
  logic [CNT_W-1:0]         cnt_sel;
  logic [TBL_W-1:0]         mean_sel, inv_sel;

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    stb_ram #(.WIDTH(CNT_W), .DEPTH(CHANNELS)) u_cnt (
      .clk     (clk),
      .we      (cnt_we),
      .waddr   (b2_r.ch),
      .wdata   (cnt_wdata[l]),
      .re      (pop),
      .raddr   (q_item.ch),
      .rd_data (cnt_rd[l])
    );
    stb_ram #(.WIDTH(TBL_W), .DEPTH(CHANNELS)) u_mean (
      .clk     (clk),
      .we      (pop && (q_item.cls == CLS_MEAN) && (q_item.lv == LV_W'(l))),
      .waddr   (q_item.ch),
      .wdata   (q_item.tv),
      .re      (pop),
      .raddr   (q_item.ch),
      .rd_data (mean_rd[l])
    );
    stb_ram #(.WIDTH(TBL_W), .DEPTH(CHANNELS)) u_inv (
      .clk     (clk),
      .we      (pop && (q_item.cls == CLS_INV) && (q_item.lv == LV_W'(l))),
      .waddr   (q_item.ch),
      .wdata   (q_item.tv),
      .re      (pop),
      .raddr   (q_item.ch),
      .rd_data (inv_rd[l])
    );
  end

  // Take the forwarded count when the previous item wrote this channel.
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      if (fwd_hit_r) begin
        cnt_old[l] = fwd_cnt_r[l];
      end else if (cnt_vld_r[b2_r.ch]) begin
        cnt_old[l] = cnt_rd[l];
      end else begin
        cnt_old[l] = '0;
      end
      cnt_new[l]   = (b2_r.hit[l] && (cnt_old[l] != CNT_MAX)) ? cnt_old[l] + 1'b1 : cnt_old[l];
      cnt_wdata[l] = b2_r.bin_end ? '0 : cnt_new[l];
    end
  end

  assign out_adv   = !out_valid_r || out_ch.ready;
  assign p2_adv    = !p2_valid_r || out_adv;
  assign p1_adv    = !p1_valid_r || p2_adv;

  assign is_sample = b2_r.cls == CLS_SAMPLE;
  assign emit      = b2_valid_r && is_sample && b2_r.bin_end;
  assign last_lvl  = b2_lvl_r == LV_W'(LEVELS - 1);
  assign p1_load   = emit && p1_adv;
  assign b2_retire = b2_valid_r && (!emit || (p1_adv && last_lvl));
  assign q_ready   = !b2_valid_r || b2_retire;
  assign pop       = q_valid && q_ready;
  assign cnt_we    = b2_retire && is_sample;

  always_comb begin
    b2_valid_nxt = b2_valid_r;
    b2_lvl_nxt   = b2_lvl_r;
    if (pop) begin
      b2_valid_nxt = 1'b1;
      b2_lvl_nxt   = '0;
    end else if (b2_retire) begin
      b2_valid_nxt = 1'b0;
    end else if (p1_load) begin
      b2_lvl_nxt = b2_lvl_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r  <= 1'b0;
      b2_lvl_r    <= '0;
      cnt_vld_r   <= '0;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b2_valid_r <= b2_valid_nxt;
      b2_lvl_r   <= b2_lvl_nxt;
      if (cnt_we) begin
        cnt_vld_r[b2_r.ch] <= 1'b1;
      end
      if (p1_adv) begin
        p1_valid_r <= emit;
      end
      if (p2_adv) begin
        p2_valid_r <= p1_valid_r;
      end
      if (out_adv) begin
        out_valid_r <= p2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b2_r      <= q_item;
      fwd_hit_r <= cnt_we && (b2_r.ch == q_item.ch);
      fwd_cnt_r <= cnt_wdata;
    end
  end

  assign cnt_sel  = cnt_new[b2_lvl_r];
  assign mean_sel = mean_rd[b2_lvl_r];
  assign inv_sel  = inv_rd[b2_lvl_r];

  // Q.8 difference, then Q.20 product, then round half up to Q8.8.
  always_ff @(posedge clk) begin
    if (p1_load) begin
      p1_diff_r <= $signed(DIFF_W'({cnt_sel, 8'b0})) - $signed(DIFF_W'(mean_sel));
      p1_inv_r  <= inv_sel;
      p1_idx_r  <= 8'(32'(b2_lvl_r) * CHANNELS + 32'(b2_r.ch));
      p1_last_r <= last_lvl;
    end
    if (p2_adv && p1_valid_r) begin
      p2_prod_r <= p1_diff_r * $signed({1'b0, p1_inv_r});
      p2_idx_r  <= p1_idx_r;
      p2_last_r <= p1_last_r;
    end
    if (out_adv && p2_valid_r) begin
      out_value_r <= sat_value;
      out_idx_r   <= p2_idx_r;
      out_last_r  <= p2_last_r;
    end
  end

  always_comb begin
    rnd = (p2_prod_r + PROD_W'(RND_HALF)) >>> RND_SHIFT;
    if (rnd > SAT_HI) begin
      sat_value = 16'sh7FFF;
    end else if (rnd < SAT_LO) begin
      sat_value = 16'sh8000;
    end else begin
      sat_value = rnd[15:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.feature_index = out_idx_r;
  assign out_ch.feature_value = out_value_r;
  assign out_ch.last          = out_last_r;

endmodule

### sv/spike_threshold_feature_binner.sv
// Throughput: one input transfer per cycle while the queue has room; a bin-end sample
//   holds the back end for its LEVELS features, one per cycle through the single
//   normalize multiplier unless the output stalls, via the p1, p2 and out registers.
// Reset (rst_n low, synchronous): pipelines and queue empty, all crossing counts read
//   as zero at once (per-channel valid bits), sigmas back to 3.0 / 4.0 / 5.0.
// Std, mean and inverse-std tables hold nothing until loaded; there is no clearing pass.
`timescale 1ns / 1ps

module spike_threshold_feature_binner import stb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  stb_in_if.sink      in_ch,
  stb_out_if.source   out_ch
);

  // Front end: takes every transfer, applies std loads, drops out-of-range
  // items, and tags samples with their three threshold hits.
  // Queue: absorbs samples while the back end emits a bin's features.
  // Back end: count read-modify-write, table loads and feature pipeline.

  sigma_t    sigma_r, sigma_nxt;
  logic      f_valid, f_ready;
  stb_item_t f_item;
  logic      q_valid, q_ready;
  stb_item_t q_item;

  // Sigma registers; a write to an index past the list is dropped.
  always_comb begin
    sigma_nxt = sigma_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SIGMA_LOW:  sigma_nxt[0] = cfg_data;
        CFG_SIGMA_MID:  sigma_nxt[1] = cfg_data;
        CFG_SIGMA_HIGH: sigma_nxt[2] = cfg_data;
        default: begin
          sigma_nxt = sigma_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r[0] <= SIGMA_LOW_RST;
      sigma_r[1] <= SIGMA_MID_RST;
      sigma_r[2] <= SIGMA_HIGH_RST;
    end else begin
      sigma_r <= sigma_nxt;
    end
  end

  stb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .sigma      (sigma_r),
    .in_ch      (in_ch),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  stb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Hold a bin-end sample here until all of its features enter the feature pipeline.
  stb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

endmodule
